>>> rtl/dsi_pkg.sv
// Package for the decimal string to int32 parser.
// Types, character codes and helpers shared by dsi_parse and the top level.
// No dependencies.
`default_nettype none

package dsi_pkg;

   localparam int CHAR_W   = 8;
   localparam int SLOT_W   = 10;
   localparam int MAG_W    = 32;
   localparam int VALUE_W  = 32;
   // room for magnitude * 10 + 9 with magnitude up to 2^31
   localparam int PROD_W   = MAG_W + 4;

   localparam int REQ_DATA_W = 24;   // 18 payload bits padded to bytes
   localparam int RSP_DATA_W = 48;   // 43 payload bits padded to bytes

   localparam logic [PROD_W-1:0] MAG_LIMIT = PROD_W'(64'd2147483648);
   localparam logic [MAG_W-1:0]  POS_LIMIT = 32'd2147483647;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

   typedef enum logic [2:0] {
      PH_LEAD   = 3'd0,
      PH_SIGN   = 3'd1,
      PH_DIGITS = 3'd2,
      PH_TRAIL  = 3'd3
   } phase_type;

   typedef struct packed {
      phase_type         phase;
      logic              negative;
      logic [MAG_W-1:0]  magnitude;
      logic              too_big;
      logic              bad_syntax;
   } parse_state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               error;
   } parse_result_type;

   localparam parse_state_type STATE_RESET = '{
      phase:      PH_LEAD,
      negative:   1'b0,
      magnitude:  '0,
      too_big:    1'b0,
      bad_syntax: 1'b0
   };

   // space, tab, newline, vertical tab, form feed, carriage return
   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

`default_nettype wire

>>> rtl/dsi_parse.sv
// One character step of the parser: next state and terminator result.
// Purely combinational; uses dsi_pkg.
`default_nettype none

module dsi_parse
   import dsi_pkg::*;
(
   input  parse_state_type   state_cur,
   input  wire [CHAR_W-1:0]  char_code,
   output parse_state_type   state_next,
   output parse_result_type  result
);

   logic [PROD_W-1:0] mag_ext;
   logic [PROD_W-1:0] prod;
   logic              dig;
   logic              spc;
   logic              err;
   parse_state_type   after_digit;

   assign mag_ext = {{(PROD_W-MAG_W){1'b0}}, state_cur.magnitude};
   // m*10 + d as two shifts and adds
   assign prod    = (mag_ext << 3) + (mag_ext << 1)
                  + {{(PROD_W-CHAR_W){1'b0}}, char_code - CHAR_ZERO};
   assign dig     = is_digit(char_code);
   assign spc     = is_space(char_code);

   // digit accumulate with sticky overflow; magnitude freezes once too big
   always_comb begin
      after_digit       = state_cur;
      after_digit.phase = PH_DIGITS;
      if (!state_cur.too_big) begin
         if (prod > MAG_LIMIT) begin
            after_digit.too_big = 1'b1;
         end else begin
            after_digit.magnitude = prod[MAG_W-1:0];
         end
      end
   end

   always_comb begin
      state_next = state_cur;
      if (char_code == CHAR_NUL) begin
         state_next = STATE_RESET;
      end else if (!state_cur.bad_syntax) begin
         case (state_cur.phase)
            PH_SIGN: begin
               if (dig) state_next = after_digit;
               else     state_next.bad_syntax = 1'b1;
            end
            PH_DIGITS: begin
               if (dig)      state_next = after_digit;
               else if (spc) state_next.phase = PH_TRAIL;
               else          state_next.bad_syntax = 1'b1;
            end
            PH_TRAIL: begin
               if (!spc) state_next.bad_syntax = 1'b1;
            end
            default: begin
               // leading whitespace, also any unused phase code
               if (spc) begin
                  state_next.phase = PH_LEAD;
               end else if (char_code == CHAR_MINUS) begin
                  state_next.negative = 1'b1;
                  state_next.phase    = PH_SIGN;
               end else if (char_code == CHAR_PLUS) begin
                  state_next.phase = PH_SIGN;
               end else if (dig) begin
                  state_next = after_digit;
               end else begin
                  state_next.bad_syntax = 1'b1;
               end
            end
         endcase
      end
   end

   // terminator result from the state before the terminator
   always_comb begin
      err = state_cur.bad_syntax || state_cur.too_big ||
            !((state_cur.phase == PH_DIGITS) || (state_cur.phase == PH_TRAIL)) ||
            (!state_cur.negative && (state_cur.magnitude > POS_LIMIT));
      result.error = err;
      if (err) begin
         result.value = '0;
      end else if (state_cur.negative) begin
         result.value = MAG_W'(0) - state_cur.magnitude;
      end else begin
         result.value = state_cur.magnitude;
      end
   end

endmodule

`default_nettype wire

>>> rtl/decimal_string_to_int32.sv
// A terminator on req passes the input register, then the result register, to rsp.
// Throughput: one character per cycle while no terminator waits on rsp; the parser
//   state loop (multiply by ten plus a phase step in dsi_parse) closes through state_ff.
// Only a terminator (zero byte) yields a result transfer; other characters none.
// Reset (synchronous, active high) empties both stages and returns the parser
//   to the leading whitespace phase.
`default_nettype none

module decimal_string_to_int32
   import dsi_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   // req_tdata: [7:0] char_code, [17:8] slot, [23:18] zero
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire [REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata: [31:0] value, [32] error, [42:33] slot_out, [47:43] zero
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // input register
   logic              in_valid_ff,  in_valid_in;
   logic [CHAR_W-1:0] in_char_ff,   in_char_in;
   logic [SLOT_W-1:0] in_slot_ff,   in_slot_in;

   // parser state
   parse_state_type   state_ff,     state_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic               out_error_ff, out_error_in;
   logic [SLOT_W-1:0]  out_slot_ff,  out_slot_in;

   parse_state_type   step_state;
   parse_result_type  step_result;
   logic              in_is_term;
   logic              out_free;
   logic              advance;

   dsi_parse u_parse (
      .state_cur  (state_ff),
      .char_code  (in_char_ff),
      .state_next (step_state),
      .result     (step_result)
   );

   assign in_is_term = (in_char_ff == CHAR_NUL);
   assign out_free   = !out_valid_ff || rsp_tready;
   // plain characters never wait on the result side; a terminator needs a free slot
   assign advance    = in_valid_ff && (!in_is_term || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_slot_in  = in_slot_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_char_in  = req_tdata[CHAR_W-1:0];
         in_slot_in  = req_tdata[CHAR_W +: SLOT_W];
      end

      state_in = advance ? step_state : state_ff;

      out_valid_in = out_valid_ff && !rsp_tready;
      out_value_in = out_value_ff;
      out_error_in = out_error_ff;
      out_slot_in  = out_slot_ff;
      if (advance && in_is_term) begin
         out_valid_in = 1'b1;
         out_value_in = step_result.value;
         out_error_in = step_result.error;
         out_slot_in  = in_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= STATE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      in_char_ff   <= in_char_in;
      in_slot_ff   <= in_slot_in;
      out_value_ff <= out_value_in;
      out_error_ff <= out_error_in;
      out_slot_ff  <= out_slot_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-VALUE_W-1-SLOT_W){1'b0}},
                        out_slot_ff, out_error_ff, out_value_ff};

`ifndef SYNTHESIS
   // an error result always carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_error_ff) |-> (out_value_ff == '0))
      else $error("error result with nonzero value");

   // a terminator that moves on always lands in the result register
   a_term_out: assert property (@(posedge clock) disable iff (reset)
      (advance && in_is_term) |=> out_valid_ff)
      else $error("terminator lost");

   // after a terminator the parser is back at its start
   a_term_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && in_is_term) |=>
         ((state_ff.phase == PH_LEAD) && (state_ff.magnitude == '0) &&
          !state_ff.too_big && !state_ff.bad_syntax && !state_ff.negative))
      else $error("parser state not cleared after terminator");

   // magnitude stays at or below 2^31
   a_mag_limit: assert property (@(posedge clock) disable iff (reset)
      ({{(PROD_W-MAG_W){1'b0}}, state_ff.magnitude} <= MAG_LIMIT))
      else $error("magnitude above limit");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for decimal_string_to_int32: streams character transfers,
// predicts each terminator result and checks the result stream field by field.
// Depends on dsi_pkg and the decimal_string_to_int32 RTL.
`timescale 1ns / 100ps

module tb;
   import dsi_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 6;
   localparam int STUCK_LIMIT  = 1000;   // cycles without any transfer
   localparam int DRAIN_CYCLES = 8;      // extra wait after the last expected result
   localparam int TOTAL_ITEMS  = 1500;
   localparam int CALM_ITEMS   = 150;    // tail of the run with no idling

   // whitespace codes the package does not name
   localparam logic [CHAR_W-1:0] CHAR_NL = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_VT = 8'd11;
   localparam logic [CHAR_W-1:0] CHAR_FF = 8'd12;

   typedef logic [CHAR_W-1:0] char_type;

   // Tracks the parser state per string and queues the value each terminator yields.
   class atoi_scoreboard;
      typedef struct {
         logic signed [VALUE_W-1:0] value;
         logic                      error;
         logic [SLOT_W-1:0]         slot;
      } parsed_int_type;

      phase_type         phase;
      logic              negative;
      logic [MAG_W-1:0]  magnitude;
      logic              too_big;
      logic              bad_syntax;
      parsed_int_type    parsed_ints[$];
      int                failures;

      function new();
         clear_string();
         failures = 0;
      endfunction

      function void clear_string();
         phase      = PH_LEAD;
         negative   = 1'b0;
         magnitude  = '0;
         too_big    = 1'b0;
         bad_syntax = 1'b0;
      endfunction

      function bit is_blank(char_type c);
         return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NL || c == CHAR_VT
             || c == CHAR_FF || c == CHAR_CR;
      endfunction

      function bit is_numeral(char_type c);
         return c >= CHAR_ZERO && c <= CHAR_NINE;
      endfunction

      // magnitude saturates: once it would pass 2^31 only the sticky flag moves
      function void add_numeral(char_type c);
         logic [63:0] sum;
         if (too_big)
            return;
         sum = 64'(magnitude) * 64'd10 + 64'(c - CHAR_ZERO);
         if (sum > 64'(MAG_LIMIT))
            too_big = 1'b1;
         else
            magnitude = sum[MAG_W-1:0];
      endfunction

      function int pending();
         return parsed_ints.size();
      endfunction

      // one accepted character transfer
      function void note_char(char_type c, logic [SLOT_W-1:0] slot);
         parsed_int_type r;
         logic           err;
         if (c == CHAR_NUL) begin
            err = bad_syntax || too_big || phase == PH_LEAD || phase == PH_SIGN;
            r.value = '0;
            if (!err) begin
               if (negative)
                  r.value = -magnitude;    // -2^31 is in range
               else if (magnitude > POS_LIMIT)
                  err = 1'b1;
               else
                  r.value = magnitude;
            end
            r.error = err;
            r.slot  = slot;
            parsed_ints.push_back(r);
            clear_string();
            return;
         end
         if (bad_syntax)
            return;                        // rest of a bad string is ignored
         case (phase)
            PH_SIGN: begin
               if (is_numeral(c)) begin
                  add_numeral(c);
                  phase = PH_DIGITS;
               end else begin
                  bad_syntax = 1'b1;
               end
            end
            PH_DIGITS: begin
               if (is_numeral(c))
                  add_numeral(c);
               else if (is_blank(c))
                  phase = PH_TRAIL;
               else
                  bad_syntax = 1'b1;
            end
            PH_TRAIL: begin
               if (!is_blank(c))
                  bad_syntax = 1'b1;
            end
            default: begin
               if (is_blank(c)) begin
                  phase = PH_LEAD;
               end else if (c == CHAR_MINUS) begin
                  negative = 1'b1;
                  phase    = PH_SIGN;
               end else if (c == CHAR_PLUS) begin
                  phase = PH_SIGN;
               end else if (is_numeral(c)) begin
                  add_numeral(c);
                  phase = PH_DIGITS;
               end else begin
                  bad_syntax = 1'b1;
               end
            end
         endcase
      endfunction

      // one accepted result transfer
      function void check_result(logic [RSP_DATA_W-1:0] data);
         parsed_int_type            want;
         logic signed [VALUE_W-1:0] got_value;
         logic                      got_error;
         logic [SLOT_W-1:0]         got_slot;
         got_value = data[31:0];
         got_error = data[32];
         got_slot  = data[42:33];
         if (parsed_ints.size() == 0) begin
            $error("result with no terminator pending: value %0d error %0d slot_out %0d",
                   got_value, got_error, got_slot);
            failures++;
            return;
         end
         want = parsed_ints.pop_front();
         if (got_value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, got_value);
            failures++;
         end
         if (got_error !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, got_error);
            failures++;
         end
         if (got_slot !== want.slot) begin
            $error("slot_out: expected %0d, got %0d", want.slot, got_slot);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;    // [7:0] char_code, [17:8] slot, [23:18] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;    // [31:0] value, [32] error, [42:33] slot_out

   atoi_scoreboard sb;
   int             items_sent  = 0;
   int             stuck_count = 0;
   int             gap_pct     = 0;     // sender idle chance, re-picked per string
   int             stall_pct   = 0;     // receiver stall chance, re-picked by the result side
   bit             calm        = 1'b0;  // no idling on either side

   decimal_string_to_int32 i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic int pick_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 10;
         2: return 30;
         default: return 60;
      endcase
   endfunction

   function automatic char_type pick_blank();
      case ($urandom_range(0, 5))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_NL;
         3: return CHAR_VT;
         4: return CHAR_FF;
         default: return CHAR_CR;
      endcase
   endfunction

   function automatic void append_text(ref char_type txt[$], input string s);
      for (int i = 0; i < s.len(); i++)
         txt.push_back(s[i]);
   endfunction

   // Mostly well-formed numbers with random padding, sign and size (many near
   // the int32 limits), some with one character spoiled; the rest is noise.
   function automatic void make_random_text(ref char_type txt[$]);
      int               kind;
      int               pos;
      longint unsigned  num;
      txt.delete();
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         repeat ($urandom_range(0, 2)) txt.push_back(pick_blank());
         case ($urandom_range(0, 2))
            1: txt.push_back(CHAR_PLUS);
            2: txt.push_back(CHAR_MINUS);
            default: ;
         endcase
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) txt.push_back(CHAR_ZERO);
         case ($urandom_range(0, 4))
            0: num = $urandom_range(0, 9);
            1: num = $urandom_range(0, 999);
            2: num = $urandom;
            3: num = 64'd2147483645 + $urandom_range(0, 6);
            default: num = {$urandom, $urandom};
         endcase
         append_text(txt, $sformatf("%0d", num));
         repeat ($urandom_range(0, 2)) txt.push_back(pick_blank());
         if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, txt.size());
            if ($urandom_range(0, 1) || pos == txt.size())
               txt.insert(pos, char_type'($urandom_range(1, 255)));
            else
               txt[pos] = char_type'($urandom_range(1, 255));
         end
      end else if (kind == 7) begin
         repeat ($urandom_range(0, 6)) txt.push_back(char_type'($urandom_range(1, 255)));
      end else begin
         // whitespace and signs only: never any digits
         repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 2))
               0: txt.push_back(pick_blank());
               1: txt.push_back(CHAR_PLUS);
               default: txt.push_back(CHAR_MINUS);
            endcase
         end
      end
   endfunction

   // Called and returns at a falling edge; holds the transfer until accepted.
   task automatic send_item(input char_type c, input logic [SLOT_W-1:0] slot);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(REQ_DATA_W - CHAR_W - SLOT_W){1'b0}}, slot, c};
      do @(posedge clock); while (!req_tready);
      sb.note_char(c, slot);
      items_sent++;
      @(negedge clock);
   endtask

   // characters carry random slots; only the terminator's slot matters
   task automatic send_string(input char_type txt[$], input logic [SLOT_W-1:0] slot);
      foreach (txt[i])
         send_item(txt[i], SLOT_W'($urandom_range(0, 1023)));
      send_item(CHAR_NUL, slot);
   endtask

   // result side: bursts of backpressure, none in the calm tail
   initial begin
      int stall_left;
      int cycle_count;
      stall_left  = 0;
      cycle_count = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(negedge clock);
         cycle_count++;
         if (cycle_count % 64 == 0)
            stall_pct = pick_pct();
         if (calm) begin
            stall_left = 0;
            rsp_tready = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready = 1'b0;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // check each result transfer; count cycles with no transfer on either side
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_count <= 0;
      else
         stuck_count <= stuck_count + 1;
   end

   initial begin
      wait (stuck_count >= STUCK_LIMIT);
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      char_type txt[$];
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty string, lone sign, padded signed value with a leading
      // zero, digit after trailing whitespace, stray top-bit byte, most negative
      gap_pct = 30;
      txt = {};
      send_string(txt, 10'd0);
      txt = {CHAR_MINUS};
      send_string(txt, 10'd1023);
      txt = {CHAR_SPACE, CHAR_PLUS, CHAR_ZERO, CHAR_NINE, CHAR_CR};
      send_string(txt, 10'h2AA);
      txt = {};
      append_text(txt, "1 2");
      send_string(txt, 10'h155);
      txt = {char_type'(CHAR_ZERO + 8'd7), 8'hFF};
      send_string(txt, 10'd1);
      txt = {};
      append_text(txt, "-2147483648");
      send_string(txt, 10'd512);

      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= TOTAL_ITEMS - CALM_ITEMS)
            calm = 1'b1;
         gap_pct = pick_pct();
         make_random_text(txt);
         send_string(txt, SLOT_W'($urandom_range(0, 1023)));
      end
      req_tvalid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
